[sv/assert_macros.svh]
// Shared assertion macros; clk and rst_n of the enclosing module are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge out of reset
`define HRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cond must never be true out of reset
`define HRP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[sv/hrp_pkg.sv]
package hrp_pkg;

  localparam int MAX_HEADERS = 16;
  localparam int HC_W        = $clog2(MAX_HEADERS + 1);

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_COLON = 8'd58;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_NO_SPACE  = 2'd1;
  localparam logic [1:0] ERR_NO_COLON  = 2'd2;
  localparam logic [1:0] ERR_TOO_MANY  = 2'd3;

  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_URL     = 3'd1,
    PH_VERSION = 3'd2,
    PH_KEY     = 3'd3,
    PH_VALUE   = 3'd4,
    PH_SKIP    = 3'd5
  } phase_t;

  localparam logic [2:0] TAG_NONE    = 3'd0;
  localparam logic [2:0] TAG_VERSION = 3'd2;
  localparam logic [2:0] TAG_KEY     = 3'd3;
  localparam logic [2:0] TAG_VALUE   = 3'd4;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic [2:0] tag;
    logic       field_end;
    logic       done;
    logic [1:0] err;
  } res_t;

  // up to two results caused by one input byte
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } q_entry_t;

  function automatic res_t mk_res(logic [7:0] data, logic has, logic [2:0] tag,
                                  logic fend, logic done, logic [1:0] err);
    res_t r;
    r.data      = has ? data : 8'd0;
    r.has_byte  = has;
    r.tag       = tag;
    r.field_end = fend;
    r.done      = done;
    r.err       = err;
    return r;
  endfunction

  function automatic q_entry_t add_res(q_entry_t e, res_t r);
    q_entry_t o;
    o = e;
    if (e.n == 2'd0) begin
      o.r0 = r;
    end else begin
      o.r1 = r;
    end
    o.n = e.n + 2'd1;
    return o;
  endfunction

endpackage

[sv/hrp_front.sv]
`include "assert_macros.svh"

module hrp_front import hrp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] in_byte,
  output logic       push,
  output q_entry_t   push_entry
);

  phase_t            phase_r, phase_nxt;
  logic              cr_r, cr_nxt;
  logic              colon_r, colon_nxt;
  logic              lhb_r, lhb_nxt;
  logic [HC_W-1:0]   hc_r, hc_nxt;
  q_entry_t          ent;
  logic              consumed;

  always_comb begin
    phase_nxt = phase_r;
    cr_nxt    = cr_r;
    colon_nxt = colon_r;
    lhb_nxt   = lhb_r;
    hc_nxt    = hc_r;
    ent       = '0;
    consumed  = 1'b0;

    if (cr_r) begin
      cr_nxt = 1'b0;
      if (in_byte == CH_LF) begin
        consumed = 1'b1;
        case (phase_nxt)
          PH_METHOD: begin
            if (lhb_nxt) begin
              ent = add_res(ent, mk_res(8'd0, 1'b0, TAG_NONE, 1'b0, 1'b0, ERR_NO_SPACE));
              phase_nxt = PH_METHOD;
              hc_nxt    = '0;
            end
          end
          PH_URL: begin
            ent = add_res(ent, mk_res(8'd0, 1'b0, TAG_NONE, 1'b0, 1'b0, ERR_NO_SPACE));
            phase_nxt = PH_METHOD;
            hc_nxt    = '0;
          end
          PH_VERSION: begin
            ent = add_res(ent, mk_res(8'd0, 1'b0, TAG_VERSION, 1'b1, 1'b0, ERR_NONE));
            phase_nxt = PH_KEY;
          end
          PH_KEY: begin
            if (lhb_nxt) begin
              ent = add_res(ent, mk_res(8'd0, 1'b0, TAG_NONE, 1'b0, 1'b0, ERR_NO_COLON));
            end else begin
              ent = add_res(ent, mk_res(8'd0, 1'b0, TAG_NONE, 1'b0, 1'b1, ERR_NONE));
              phase_nxt = PH_METHOD;
              hc_nxt    = '0;
            end
          end
          PH_VALUE: begin
            ent = add_res(ent, mk_res(8'd0, 1'b0, TAG_VALUE, 1'b1, 1'b0, ERR_NONE));
            phase_nxt = PH_KEY;
          end
          default: begin
            phase_nxt = PH_KEY;
          end
        endcase
        lhb_nxt = 1'b0;
      end else begin
        if (phase_nxt != PH_SKIP) begin
          ent = add_res(ent, mk_res(CH_CR, 1'b1, phase_nxt, 1'b0, 1'b0, ERR_NONE));
        end
        lhb_nxt = 1'b1;
      end
    end else if (colon_r) begin
      colon_nxt = 1'b0;
      if (in_byte == CH_SP) begin
        consumed = 1'b1;
        if (hc_nxt >= HC_W'(MAX_HEADERS)) begin
          ent = add_res(ent, mk_res(8'd0, 1'b0, TAG_NONE, 1'b0, 1'b0, ERR_TOO_MANY));
          phase_nxt = PH_SKIP;
        end else begin
          hc_nxt = hc_nxt + HC_W'(1);
          ent = add_res(ent, mk_res(8'd0, 1'b0, TAG_KEY, 1'b1, 1'b0, ERR_NONE));
          phase_nxt = PH_VALUE;
        end
      end else begin
        ent = add_res(ent, mk_res(CH_COLON, 1'b1, TAG_KEY, 1'b0, 1'b0, ERR_NONE));
      end
    end

    if (!consumed) begin
      if (in_byte == CH_CR) begin
        cr_nxt = 1'b1;
      end else begin
        lhb_nxt = 1'b1;
        case (phase_nxt)
          PH_METHOD, PH_URL: begin
            if (in_byte == CH_SP) begin
              ent = add_res(ent, mk_res(8'd0, 1'b0, phase_nxt, 1'b1, 1'b0, ERR_NONE));
              phase_nxt = (phase_nxt == PH_METHOD) ? PH_URL : PH_VERSION;
            end else begin
              ent = add_res(ent, mk_res(in_byte, 1'b1, phase_nxt, 1'b0, 1'b0, ERR_NONE));
            end
          end
          PH_VERSION, PH_VALUE: begin
            ent = add_res(ent, mk_res(in_byte, 1'b1, phase_nxt, 1'b0, 1'b0, ERR_NONE));
          end
          PH_KEY: begin
            if (in_byte == CH_COLON) begin
              colon_nxt = 1'b1;
            end else begin
              ent = add_res(ent, mk_res(in_byte, 1'b1, TAG_KEY, 1'b0, 1'b0, ERR_NONE));
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign push       = take && (ent.n != 2'd0);
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_METHOD;
      cr_r    <= 1'b0;
      colon_r <= 1'b0;
      lhb_r   <= 1'b0;
      hc_r    <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      cr_r    <= cr_nxt;
      colon_r <= colon_nxt;
      lhb_r   <= lhb_nxt;
      hc_r    <= hc_nxt;
    end
  end

  `HRP_ASSERT(a_hc_bound, hc_r <= HC_W'(MAX_HEADERS), "header count above limit")
  `HRP_NEVER(a_both_held, cr_r && colon_r, "CR and colon held together")

endmodule

[sv/hrp_queue.sv]
`include "assert_macros.svh"

module hrp_queue import hrp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output logic     full,
  output logic     empty,
  output q_entry_t head
);

  q_entry_t        mem [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, rp_r;
  logic [Q_CW-1:0] cnt_r;

  assign full  = (cnt_r == Q_CW'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + Q_AW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + Q_AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + Q_CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - Q_CW'(1);
      end
    end
  end

  `HRP_NEVER(a_push_full, push && full, "push into full queue")
  `HRP_NEVER(a_pop_empty, pop && empty, "pop from empty queue")

endmodule

[sv/hrp_back.sv]
`include "assert_macros.svh"

module hrp_back import hrp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       empty,
  input  q_entry_t   head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic [2:0] out_field_tag,
  output logic       out_field_end,
  output logic       out_request_done,
  output logic [1:0] out_error_code,
  output logic       out_last
);

  logic sel_r, sel_nxt;
  logic two;
  logic beat;
  res_t cur;

  assign two  = (head.n == 2'd2);
  assign cur  = sel_r ? head.r1 : head.r0;
  assign beat = out_valid && !out_stall;

  assign out_valid        = !empty;
  assign out_byte         = cur.data;
  assign out_has_byte     = cur.has_byte;
  assign out_field_tag    = cur.tag;
  assign out_field_end    = cur.field_end;
  assign out_request_done = cur.done;
  assign out_error_code   = cur.err;
  assign out_last         = two ? sel_r : 1'b1;

  always_comb begin
    sel_nxt = sel_r;
    pop     = 1'b0;
    if (beat) begin
      if (two && !sel_r) begin
        sel_nxt = 1'b1;
      end else begin
        sel_nxt = 1'b0;
        pop     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

  `HRP_ASSERT(a_sel_two, !sel_r || (!empty && two), "second result without a pair")

endmodule

[sv/http_request_head_parser.sv]
// Request head parser: one byte per cycle is accepted while the four-entry result
// queue has room; each byte yields zero, one or two results, and the output side
// delivers one result per cycle while out_stall is low, popping a byte's queue
// entry after its last result. Bytes with no result (held CR or colon, dropped
// bytes) never enter the queue; an accepted byte's results are registered there.
module http_request_head_parser import hrp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic [2:0] out_field_tag,
  output logic       out_field_end,
  output logic       out_request_done,
  output logic [1:0] out_error_code,
  output logic       out_last
);

  logic     take;
  logic     push, pop, full, empty;
  q_entry_t push_entry, head;

  assign in_stall = full;
  assign take     = in_valid && !full;

  hrp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .in_byte    (in_byte),
    .push       (push),
    .push_entry (push_entry)
  );

  hrp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .empty      (empty),
    .head       (head)
  );

  hrp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .empty            (empty),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_has_byte     (out_has_byte),
    .out_field_tag    (out_field_tag),
    .out_field_end    (out_field_end),
    .out_request_done (out_request_done),
    .out_error_code   (out_error_code),
    .out_last         (out_last)
  );

endmodule

[verif/http_request_head_parser_tb.sv]
`timescale 1ns / 100ps

import hrp_pkg::*;

typedef struct packed {
  logic [7:0] data;
  logic       has_byte;
  logic [2:0] tag;
  logic       field_end;
  logic       done;
  logic [1:0] err;
  logic       last;
} head_beat_t;

class head_scoreboard;
  phase_t     phase;
  bit         cr_held;
  bit         colon_held;
  bit         line_busy;
  int         hdr_count;
  head_beat_t expected_q[$];
  int         errors;

  function new();
    phase      = PH_METHOD;
    cr_held    = 0;
    colon_held = 0;
    line_busy  = 0;
    hdr_count  = 0;
    errors     = 0;
  endfunction

  function void add_beat(logic [7:0] d, logic has, logic [2:0] tag, logic fend,
                         logic done, logic [1:0] err);
    head_beat_t e;
    e = '{d, has, tag, fend, done, err, 1'b0};
    expected_q.push_back(e);
  endfunction

  function void restart();
    phase     = PH_METHOD;
    hdr_count = 0;
  endfunction

  function void close_line();
    case (phase)
      PH_METHOD: begin
        if (line_busy) begin
          add_beat(8'd0, 0, TAG_NONE, 0, 0, ERR_NO_SPACE);
          restart();
        end
      end
      PH_URL: begin
        add_beat(8'd0, 0, TAG_NONE, 0, 0, ERR_NO_SPACE);
        restart();
      end
      PH_VERSION: begin
        add_beat(8'd0, 0, TAG_VERSION, 1, 0, ERR_NONE);
        phase = PH_KEY;
      end
      PH_KEY: begin
        if (line_busy) begin
          add_beat(8'd0, 0, TAG_NONE, 0, 0, ERR_NO_COLON);
        end else begin
          add_beat(8'd0, 0, TAG_NONE, 0, 1, ERR_NONE);
          restart();
        end
      end
      PH_VALUE: begin
        add_beat(8'd0, 0, TAG_VALUE, 1, 0, ERR_NONE);
        phase = PH_KEY;
      end
      default: phase = PH_KEY;
    endcase
    line_busy = 0;
  endfunction

  // returns how many result beats this input byte causes
  function int note_byte(logic [7:0] b);
    int  n0;
    bit  consumed;
    n0       = expected_q.size();
    consumed = 0;
    if (cr_held) begin
      cr_held = 0;
      if (b == CH_LF) begin
        close_line();
        consumed = 1;
      end else begin
        if (phase != PH_SKIP) add_beat(CH_CR, 1, 3'(phase), 0, 0, ERR_NONE);
        line_busy = 1;
      end
    end else if (colon_held) begin
      colon_held = 0;
      if (b == CH_SP) begin
        if (hdr_count >= MAX_HEADERS) begin
          add_beat(8'd0, 0, TAG_NONE, 0, 0, ERR_TOO_MANY);
          phase = PH_SKIP;
        end else begin
          hdr_count++;
          add_beat(8'd0, 0, TAG_KEY, 1, 0, ERR_NONE);
          phase = PH_VALUE;
        end
        consumed = 1;
      end else begin
        add_beat(CH_COLON, 1, TAG_KEY, 0, 0, ERR_NONE);
      end
    end
    if (!consumed) begin
      if (b == CH_CR) begin
        cr_held = 1;
      end else begin
        line_busy = 1;
        case (phase)
          PH_METHOD, PH_URL: begin
            if (b == CH_SP) begin
              add_beat(8'd0, 0, 3'(phase), 1, 0, ERR_NONE);
              phase = (phase == PH_METHOD) ? PH_URL : PH_VERSION;
            end else begin
              add_beat(b, 1, 3'(phase), 0, 0, ERR_NONE);
            end
          end
          PH_VERSION, PH_VALUE: add_beat(b, 1, 3'(phase), 0, 0, ERR_NONE);
          PH_KEY: begin
            if (b == CH_COLON) colon_held = 1;
            else add_beat(b, 1, TAG_KEY, 0, 0, ERR_NONE);
          end
          default: ;
        endcase
      end
    end
    if (expected_q.size() > n0) expected_q[expected_q.size() - 1].last = 1'b1;
    return expected_q.size() - n0;
  endfunction

  function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_beat(head_beat_t got);
    head_beat_t e;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected beat, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    compare_field("out_byte", e.data, got.data);
    compare_field("out_has_byte", e.has_byte, got.has_byte);
    compare_field("out_field_tag", e.tag, got.tag);
    compare_field("out_field_end", e.field_end, got.field_end);
    compare_field("out_request_done", e.done, got.done);
    compare_field("out_error_code", e.err, got.err);
    compare_field("out_last", e.last, got.last);
  endfunction
endclass

module http_request_head_parser_tb;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_has_byte;
  logic [2:0] out_field_tag;
  logic       out_field_end;
  logic       out_request_done;
  logic [1:0] out_error_code;
  logic       out_last;

  head_scoreboard sb;
  int             burst_left = 0;
  int             fed = 0;
  logic [7:0]     directed_seq [0:30];

  http_request_head_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_has_byte     (out_has_byte),
    .out_field_tag    (out_field_tag),
    .out_field_end    (out_field_end),
    .out_request_done (out_request_done),
    .out_error_code   (out_error_code),
    .out_last         (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    void'(sb.note_byte(b));
    fed++;
    burst_left--;
  endtask

  function automatic logic [7:0] rand_char(logic [7:0] avoid);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == avoid);
    return c;
  endfunction

  task automatic send_field(input int len, input logic [7:0] avoid);
    for (int i = 0; i < len; i++) send_byte(rand_char(avoid));
  endtask

  task automatic send_crlf();
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  task automatic send_request(input int hdrs);
    send_field($urandom_range(1, 4), CH_SP);
    send_byte(CH_SP);
    send_field($urandom_range(0, 5), CH_SP);
    send_byte(CH_SP);
    send_field($urandom_range(1, 4), CH_CR);
    send_crlf();
    for (int h = 0; h < hdrs; h++) begin
      if ($urandom_range(0, 9) == 0) begin
        // header line with no colon-space
        send_field($urandom_range(1, 4), CH_COLON);
      end else begin
        send_field($urandom_range(0, 3), CH_COLON);
        send_byte(CH_COLON);
        send_byte(CH_SP);
        send_field($urandom_range(0, 4), CH_CR);
      end
      send_crlf();
    end
    send_crlf();
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 2))
      0: for (int i = $urandom_range(1, 6); i > 0; i--) send_byte(8'($urandom_range(0, 255)));
      1: begin
        send_field($urandom_range(1, 4), CH_SP);
        send_crlf();
      end
      default: begin
        send_field($urandom_range(1, 3), CH_SP);
        send_byte(CH_SP);
        send_field($urandom_range(0, 3), CH_SP);
        send_crlf();
      end
    endcase
  endtask

  // result side: checks accepted beats, stalls on its own pattern
  initial begin : result_side
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_beat('{out_byte, out_has_byte, out_field_tag, out_field_end,
                        out_request_done, out_error_code, out_last});
      cyc++;
      if ((cyc % 1200) >= 300 && (cyc % 1200) < 380) begin
        out_stall <= 1'b1;
      end else begin
        case ((cyc / 150) % 3)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    int hdrs;
    sb = new();
    directed_seq = '{CH_CR, CH_LF,
                     8'h00, CH_SP, 8'hFF, CH_CR, CH_LF,
                     "G", CH_CR, CH_LF,
                     CH_SP, "a", CH_CR, "b", CH_SP, "V", CH_CR, CH_LF,
                     "k", CH_COLON, "v", CH_CR, CH_LF,
                     "k", CH_COLON, CH_SP, CH_LF, CH_CR, CH_LF,
                     CH_CR, CH_LF};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_seq[i]) send_byte(directed_seq[i]);

    // first random request carries one header line more than the header limit
    send_request(MAX_HEADERS + 1);
    while (fed < 600) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      if ($urandom_range(0, 11) == 0) hdrs = MAX_HEADERS + $urandom_range(1, 2);
      else hdrs = $urandom_range(0, 3);
      send_request(hdrs);
    end
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
